>>> design/wfc_pkg.sv
`timescale 1ns / 1ps
package wfc_pkg;

  localparam int MAX_WAYPOINTS     = 256;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ADDR_W            = $clog2(MAX_WAYPOINTS);
  localparam int LEN_W             = ADDR_W + 1;
  localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);

  localparam int CW      = 40;   // CORDIC x/y datapath
  localparam int ZW      = 32;   // CORDIC angle, radians Q.24
  localparam int DIST_W  = 34;
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 35;

  localparam logic signed [ZW-1:0] PI_Q24       = 32'sd52707179;
  localparam logic signed [ZW-1:0] PI_Q13       = 32'sd25736;
  localparam logic signed [ZW-1:0] TWO_PI_Q13   = 32'sd51472;
  localparam logic signed [ZW-1:0] HALF_PI_Q13  = 32'sd12868;
  localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_APPEND  = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  localparam logic [1:0] STAT_DRIVE   = 2'd0;
  localparam logic [1:0] STAT_NO_PATH = 2'd1;
  localparam logic [1:0] STAT_NO_POSE = 2'd2;
  localparam logic [1:0] STAT_REACHED = 2'd3;

  localparam logic [2:0] REG_LIN_GAIN = 3'd0;
  localparam logic [2:0] REG_ANG_GAIN = 3'd1;
  localparam logic [2:0] REG_MAX_LIN  = 3'd2;
  localparam logic [2:0] REG_MAX_ANG  = 3'd3;
  localparam logic [2:0] REG_TOL      = 3'd4;

  typedef struct packed {
    logic                 start;
    logic [MUL_A_W-1:0]   a;
    logic [MUL_B_W-1:0]   b;
  } mul_req_t;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [ITER_W-1:0] i);
    logic signed [ZW-1:0] t;
    case (5'(i))
      5'd0:  t = 32'sd13176795;
      5'd1:  t = 32'sd7778716;
      5'd2:  t = 32'sd4110060;
      5'd3:  t = 32'sd2086331;
      5'd4:  t = 32'sd1047214;
      5'd5:  t = 32'sd524117;
      5'd6:  t = 32'sd262123;
      5'd7:  t = 32'sd131069;
      5'd8:  t = 32'sd65536;
      5'd9:  t = 32'sd32768;
      5'd10: t = 32'sd16384;
      5'd11: t = 32'sd8192;
      5'd12: t = 32'sd4096;
      5'd13: t = 32'sd2048;
      5'd14: t = 32'sd1024;
      5'd15: t = 32'sd512;
      5'd16: t = 32'sd256;
      5'd17: t = 32'sd128;
      5'd18: t = 32'sd64;
      5'd19: t = 32'sd32;
      5'd20: t = 32'sd16;
      5'd21: t = 32'sd8;
      5'd22: t = 32'sd4;
      5'd23: t = 32'sd2;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> design/waypoint_follower_controller.sv
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// input    in_valid / in_stall  command, waypoint_x/y, pose_valid, pose_x/y, quat_x/y/z/w
// output   out_valid/out_stall  status, linear_speed, angular_rate, target_index, path_complete
// config   cfg_valid/cfg_ready  cfg_index, cfg_data (ready always high)
//
// Clear and append give no result beat. A tick with nothing to track or no pose
// goes straight to the result; a full tick runs the shared CORDIC stage (up to
// three passes) and the serial multiplier (a product with start and done, up
// to three). in_stall is high while a beat is being worked on.
// A finished result waits in the output register and a new beat may be taken.
// Reset is synchronous; the waypoint store is not cleared.
module waypoint_follower_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [31:0] waypoint_x,
  input  logic signed [31:0] waypoint_y,
  input  logic               pose_valid,
  input  logic signed [31:0] pose_x,
  input  logic signed [31:0] pose_y,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [15:0]        linear_speed,
  output logic signed [15:0] angular_rate,
  output logic [8:0]         target_index,
  output logic               path_complete,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import wfc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RD   = 5'd1;
  localparam logic [4:0] S_PREV = 5'd2;
  localparam logic [4:0] S_VEC  = 5'd3;
  localparam logic [4:0] S_POSV = 5'd4;
  localparam logic [4:0] S_MULD = 5'd5;
  localparam logic [4:0] S_CHK  = 5'd6;
  localparam logic [4:0] S_QUAT = 5'd7;
  localparam logic [4:0] S_ERR  = 5'd8;
  localparam logic [4:0] S_ANG  = 5'd9;
  localparam logic [4:0] S_ROT  = 5'd10;
  localparam logic [4:0] S_COS  = 5'd11;
  localparam logic [4:0] S_MULG = 5'd12;
  localparam logic [4:0] S_MULC = 5'd13;
  localparam logic [4:0] S_LIN  = 5'd14;
  localparam logic [4:0] S_DONE = 5'd15;

  logic [4:0] state;

  logic [15:0] lin_gain, ang_gain, max_lin;
  logic [14:0] max_ang;
  logic [30:0] tol;

  logic [31:0] mem_x [MAX_WAYPOINTS];
  logic [31:0] mem_y [MAX_WAYPOINTS];
  logic [31:0] rd_x, rd_y;
  logic [LEN_W-1:0] path_length, current_target, idx;

  logic signed [31:0] px, py;
  logic signed [15:0] qx, qy, qz, qw;

  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [ITER_W-1:0]    it;
  logic                 rot_mode, pass2;
  logic [1:0]           qstep;
  logic signed [33:0]   acc_s, acc_c;

  logic signed [ZW-1:0] bear;
  logic [DIST_W-1:0]    range_q16;
  logic signed [17:0]   err;
  logic [14:0]          cosv;

  logic [1:0]         r_status;
  logic [15:0]        r_lin;
  logic signed [15:0] r_ang;
  logic               r_complete;

  mul_req_t           mreq;
  logic               mdone;
  logic [MUL_A_W-1:0] mprod;

  wfc_mul_serial u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .done    (mdone),
    .product (mprod)
  );

  logic in_acc;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_gain <= 16'd256;
      ang_gain <= 16'd512;
      max_lin  <= 16'd2048;
      max_ang  <= 15'd6144;
      tol      <= 31'd9830;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LIN_GAIN: lin_gain <= cfg_data[15:0];
        REG_ANG_GAIN: ang_gain <= cfg_data[15:0];
        REG_MAX_LIN:  max_lin  <= cfg_data[15:0];
        REG_MAX_ANG:  max_ang  <= cfg_data[14:0];
        REG_TOL:      tol      <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic mem_we;
  assign mem_we = in_acc && (command == CMD_APPEND)
                  && (path_length < LEN_W'(MAX_WAYPOINTS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[path_length[ADDR_W-1:0]] <= waypoint_x;
      mem_y[path_length[ADDR_W-1:0]] <= waypoint_y;
    end
    rd_x <= mem_x[current_target[ADDR_W-1:0]];
    rd_y <= mem_y[current_target[ADDR_W-1:0]];
  end

  // shared CORDIC micro-rotation
  logic signed [CW-1:0] shx, shy, nx, ny;
  logic signed [ZW-1:0] nz, at;
  logic                 dir_pos;
  always_comb begin
    shx = cx >>> it;
    shy = cy >>> it;
    at  = atan_q24(it);
    dir_pos = rot_mode ? (cz < 0) : (cy >= 0);
    if (dir_pos) begin
      nx = cx + shy;
      ny = cy - shx;
      nz = rot_mode ? cz + at : cz + at;
    end else begin
      nx = cx - shy;
      ny = cy + shx;
      nz = cz - at;
    end
  end

  // small datapath pieces
  logic signed [32:0] dx, dy;
  logic signed [31:0] qprod, bear13, yaw13, err_w;
  logic signed [34:0] ang_p;
  logic signed [25:0] ang_q;
  logic signed [CW-1:0] cos_r;
  logic [MUL_A_W-1:0] round_d, round_l;
  logic [37:0] lin_full;
  logic [LEN_W-1:0] idx_inc;

  always_comb begin
    dx = {rd_x[31], rd_x} - {px[31], px};
    dy = {rd_y[31], rd_y} - {py[31], py};
    case (qstep)
      2'd0:    qprod = qw * qz;
      2'd1:    qprod = qx * qy;
      2'd2:    qprod = qy * qy;
      default: qprod = qz * qz;
    endcase
    bear13 = (bear + 32'sd1024) >>> 11;
    yaw13  = (cz + 32'sd1024) >>> 11;
    err_w  = bear13 - yaw13;
    if (err_w > PI_Q13)       err_w = err_w - TWO_PI_Q13;
    else if (err_w < -PI_Q13) err_w = err_w + TWO_PI_Q13;
    ang_p  = $signed({1'b0, ang_gain}) * err;
    ang_q  = 26'((ang_p + 35'sd256) >>> 9);
    cos_r  = (cx + 40'sd32768) >>> 16;
    round_d  = mprod + 64'd536870912;
    round_l  = mprod + 64'd33554432;
    lin_full = round_l[63:26];
    idx_inc  = idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      path_length    <= '0;
      current_target <= '0;
      out_valid      <= 1'b0;
      mreq.start     <= 1'b0;
      it             <= '0;
      qstep          <= '0;
    end else begin
      mreq.start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            idx <= current_target;
            px  <= pose_x;
            py  <= pose_y;
            qx  <= quat_x;
            qy  <= quat_y;
            qz  <= quat_z;
            qw  <= quat_w;
            r_lin <= '0;
            r_ang <= '0;
            case (command)
              CMD_CLEAR: begin
                path_length    <= '0;
                current_target <= '0;
              end
              CMD_APPEND: begin
                if (mem_we) path_length <= path_length + 1'b1;
              end
              CMD_TICK: begin
                if (path_length == '0 || current_target >= path_length) begin
                  r_status   <= STAT_NO_PATH;
                  r_complete <= 1'b1;
                  state      <= S_DONE;
                end else if (!pose_valid) begin
                  r_status   <= STAT_NO_POSE;
                  r_complete <= 1'b0;
                  state      <= S_DONE;
                end else begin
                  state <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          cx    <= CW'(dx);
          cy    <= CW'(dy);
          pass2 <= 1'b0;
          state <= S_PREV;
        end
        S_PREV: begin
          rot_mode <= 1'b0;
          it       <= '0;
          if (cx == '0 && cy == '0) begin
            cz    <= '0;
            state <= S_POSV;
          end else begin
            if (cx < 0) begin
              cz <= (cy >= 0) ? PI_Q24 : -PI_Q24;
              cx <= -cx;
              cy <= -cy;
            end else begin
              cz <= '0;
            end
            state <= S_VEC;
          end
        end
        S_VEC, S_ROT: begin
          cx <= nx;
          cy <= ny;
          cz <= nz;
          it <= it + 1'b1;
          if (it == ITER_W'(CORDIC_ITERATIONS - 1)) begin
            state <= (state == S_VEC) ? S_POSV : S_COS;
          end
        end
        S_POSV: begin
          if (!pass2) begin
            bear       <= cz;
            mreq.start <= 1'b1;
            mreq.a     <= (cx > 0) ? MUL_A_W'(cx) : '0;
            mreq.b     <= MUL_B_W'(INV_GAIN_Q30);
            state      <= S_MULD;
          end else begin
            state <= S_ERR;
          end
        end
        S_MULD: begin
          if (mdone) begin
            range_q16 <= round_d[DIST_W+29:30];
            state     <= S_CHK;
          end
        end
        S_CHK: begin
          if (range_q16 < DIST_W'(tol)) begin
            current_target <= idx_inc;
            r_status       <= STAT_REACHED;
            r_complete     <= (idx_inc >= path_length);
            state          <= S_DONE;
          end else begin
            qstep <= '0;
            acc_s <= '0;
            acc_c <= '0;
            state <= S_QUAT;
          end
        end
        S_QUAT: begin
          qstep <= qstep + 1'b1;
          if (qstep[1]) acc_c <= acc_c + 34'(qprod);
          else          acc_s <= acc_s + 34'(qprod);
          if (qstep == 2'd3) begin
            cy    <= CW'(acc_s <<< 1);
            cx    <= CW'(35'sd268435456 - ((35'(acc_c) + 35'(qprod)) <<< 1));
            pass2 <= 1'b1;
            state <= S_PREV;
          end
        end
        S_ERR: begin
          err   <= 18'(err_w);
          state <= S_ANG;
        end
        S_ANG: begin
          if (ang_q > $signed({11'b0, max_ang}))       r_ang <= $signed({1'b0, max_ang});
          else if (ang_q < -$signed({11'b0, max_ang})) r_ang <= -$signed({1'b0, max_ang});
          else                                         r_ang <= 16'(ang_q);
          r_status   <= STAT_DRIVE;
          r_complete <= 1'b0;
          if (32'(err) <= HALF_PI_Q13 && 32'(err) >= -HALF_PI_Q13) begin
            cx       <= CW'(INV_GAIN_Q30);
            cy       <= '0;
            cz       <= ZW'($signed({err, 11'b0}));
            rot_mode <= 1'b1;
            it       <= '0;
            state    <= S_ROT;
          end else begin
            state <= S_DONE;
          end
        end
        S_COS: begin
          if (cos_r < 0)              cosv <= '0;
          else if (cos_r > 40'sd16384) cosv <= 15'd16384;
          else                        cosv <= 15'(cos_r);
          state <= S_MULG;
          mreq.start <= 1'b1;
          mreq.a     <= MUL_A_W'(lin_gain);
          mreq.b     <= MUL_B_W'(range_q16);
        end
        S_MULG: begin
          if (mdone) begin
            mreq.start <= 1'b1;
            mreq.a     <= mprod;
            mreq.b     <= MUL_B_W'(cosv);
            state      <= S_MULC;
          end
        end
        S_MULC: begin
          if (mdone) state <= S_LIN;
        end
        S_LIN: begin
          r_lin <= (lin_full > 38'(max_lin)) ? max_lin : lin_full[15:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            status        <= r_status;
            linear_speed  <= r_lin;
            angular_rate  <= r_ang;
            target_index  <= 9'(idx);
            path_complete <= r_complete;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/wfc_mul_serial.sv
`timescale 1ns / 1ps
module wfc_mul_serial (
  input  logic                     clk,
  input  logic                     rst,
  input  wfc_pkg::mul_req_t        req,
  output logic                     done,
  output logic [wfc_pkg::MUL_A_W-1:0] product
);
  import wfc_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_A_W-1:0] a_sh;
  logic [MUL_B_W-1:0] b_sh;
  logic [MUL_A_W-1:0] acc;

  // shift-add, one multiplier bit a cycle, product kept modulo 2^64
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        a_sh <= req.a;
        b_sh <= req.b;
      end else if (busy) begin
        if (b_sh[0]) acc <= acc + a_sh;
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

>>> design/wfc_checker.sv
`timescale 1ns / 1ps
module wfc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic [15:0]        linear_speed,
  input logic signed [15:0] angular_rate,
  input logic               path_complete
);
  import wfc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(linear_speed))
    else $error("stalled result beat changed");

  a_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_DRIVE |-> linear_speed == 16'd0 && angular_rate == 16'sd0)
    else $error("non-zero command on a stop result");

  a_nopath: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_NO_PATH) |-> path_complete)
    else $error("no-path result without path_complete");

  a_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_NO_POSE || status == STAT_DRIVE) |-> !path_complete)
    else $error("active path flagged complete");

endmodule

bind waypoint_follower_controller wfc_checker u_wfc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .linear_speed  (linear_speed),
  .angular_rate  (angular_rate),
  .path_complete (path_complete)
);
